// ===== hdl/gsmf_pkg.sv =====
package gsmf_pkg;

    // Window geometry
    localparam int WINDOW_SIZE = 5;
    localparam int HALF_SPAN   = WINDOW_SIZE / 2;
    localparam int SPAN        = 2 * HALF_SPAN + 1;

    // Field and counter widths
    localparam int DATA_W = 16;
    localparam int SEEN_W = $clog2(SPAN + 1);
    localparam int DC_W   = $clog2(HALF_SPAN + 1);
    localparam int IDX_W  = $clog2(SPAN);

    // Request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);
    localparam logic [DATA_W-1:0]    RANGE_LOW_RESET  = DATA_W'(20);
    localparam logic [DATA_W-1:0]    RANGE_HIGH_RESET = DATA_W'(12000);

    typedef logic [DATA_W-1:0] sample_t;

    // One queued request: window snapshot (index 0 newest), fill count, end flag
    typedef struct packed {
        sample_t [SPAN-1:0] win;
        logic [SEEN_W-1:0]  seen;
        logic               scan_end;
    } job_t;

    typedef struct packed {
        sample_t low;
        sample_t high;
    } limits_t;

endpackage

// ===== hdl/gsmf_front.sv =====
module gsmf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gsmf_pkg::sample_t range_sample,
    input  logic            scan_end,
    output logic            job_valid,
    output gsmf_pkg::job_t  job,
    input  logic            job_ready
);
    import gsmf_pkg::*;

    sample_t [SPAN-1:0] win_reg;
    sample_t [SPAN-1:0] win_next;
    logic [SEEN_W-1:0]  seen_reg;
    logic [SEEN_W-1:0]  seen_next;
    sample_t [SPAN-1:0] win_shift;
    logic [SEEN_W-1:0]  seen_inc;
    logic               accept;

    // Shift the new sample in and count it, saturating at the span
    always_comb
    begin
        win_shift = {win_reg[SPAN-2:0], range_sample};
        if (seen_reg == SEEN_W'(SPAN))
        begin
            seen_inc = seen_reg;
        end
        else
        begin
            seen_inc = seen_reg + 1'b1;
        end
    end

    // Classify: a request goes to the back only if it yields results
    assign in_ready  = job_ready;
    assign accept    = in_valid && job_ready;
    assign job_valid = in_valid && (scan_end || (seen_inc > SEEN_W'(HALF_SPAN)));
    assign job       = '{win: win_shift, seen: seen_inc, scan_end: scan_end};

    // Advance the window; drop it at the end of a scan
    always_comb
    begin
        win_next  = win_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (scan_end)
            begin
                win_next  = '0;
                seen_next = '0;
            end
            else
            begin
                win_next  = win_shift;
                seen_next = seen_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== hdl/gsmf_queue.sv =====
module gsmf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  gsmf_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output gsmf_pkg::job_t pop_job
);
    import gsmf_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/gsmf_back.sv =====
module gsmf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gsmf_pkg::limits_t limits,
    input  logic              job_valid,
    output logic              job_ready,
    input  gsmf_pkg::job_t    job,
    output logic              out_valid,
    input  logic              out_ready,
    output gsmf_pkg::sample_t filtered_range,
    output logic              last_of_scan
);
    import gsmf_pkg::*;

    // Expansion of one request into its positions
    logic              busy_reg;
    logic              busy_next;
    logic [DC_W-1:0]   dc_reg;
    logic [DC_W-1:0]   dc_next;
    logic [DC_W-1:0]   cur_dc;
    logic [SEEN_W-1:0] start_dc;
    logic [SEEN_W-1:0] hi_off;
    logic [SEEN_W-1:0] reach;
    logic              step_last;
    logic              issue;

    // Stage one: gating and pairwise order
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    sample_t [SPAN-1:0]        s1_vals_reg;
    logic [SPAN-1:0]           s1_mask_reg;
    logic [SPAN-1:0]           s1_mask_next;
    logic [SPAN-1:0][SPAN-1:0] s1_before_reg;
    logic [SPAN-1:0][SPAN-1:0] s1_before_next;
    sample_t                   s1_raw_reg;
    logic                      s1_last_reg;
    logic                      s1_free;

    // Stage two: rank select into the output register
    logic [SEEN_W-1:0]   valid_cnt;
    logic [SEEN_W-1:0]   rank [SPAN];
    logic [SPAN-1:0]     sel;
    sample_t             median;
    logic                out_valid_reg;
    logic                out_valid_next;
    sample_t             out_value_reg;
    logic                out_last_reg;
    logic                out_load;

    // Pick the center offset for this step
    always_comb
    begin
        if (!job.scan_end)
        begin
            start_dc = SEEN_W'(HALF_SPAN);
        end
        else if (job.seen - 1'b1 > SEEN_W'(HALF_SPAN))
        begin
            start_dc = SEEN_W'(HALF_SPAN);
        end
        else
        begin
            start_dc = job.seen - 1'b1;
        end
        cur_dc    = busy_reg ? dc_reg : start_dc[DC_W-1:0];
        step_last = !job.scan_end || (cur_dc == '0);
        reach     = SEEN_W'(cur_dc) + SEEN_W'(HALF_SPAN);
        hi_off    = (reach > job.seen - 1'b1) ? job.seen - 1'b1 : reach;
    end

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free   = !s1_valid_reg || out_load;
    assign issue     = job_valid && s1_free;
    assign job_ready = issue && step_last;

    // Hold the request until its last position is issued
    always_comb
    begin
        busy_next = busy_reg;
        dc_next   = dc_reg;
        if (issue)
        begin
            busy_next = !step_last;
            dc_next   = cur_dc - 1'b1;
        end
    end

    // Gate samples by window edge and range limits, order them pairwise
    always_comb
    begin
        for (int k = 0; k < SPAN; k++)
        begin
            s1_mask_next[k] = (SEEN_W'(k) <= hi_off)
                && (job.win[k] >= limits.low) && (job.win[k] <= limits.high);
        end
        for (int i = 0; i < SPAN; i++)
        begin
            for (int j = 0; j < SPAN; j++)
            begin
                if (i == j)
                begin
                    s1_before_next[i][j] = 1'b0;
                end
                else
                begin
                    s1_before_next[i][j] = (job.win[j] < job.win[i])
                        || ((job.win[j] == job.win[i]) && (j < i));
                end
            end
        end
    end

    assign s1_valid_next = issue ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            dc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            dc_reg        <= dc_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_vals_reg   <= job.win;
            s1_mask_reg   <= s1_mask_next;
            s1_before_reg <= s1_before_next;
            s1_raw_reg    <= job.win[IDX_W'(cur_dc)];
            s1_last_reg   <= job.scan_end && (cur_dc == '0);
        end
    end

    // Select the valid sample whose rank is count/2
    always_comb
    begin
        valid_cnt = SEEN_W'($countones(s1_mask_reg));
        median    = '0;
        for (int i = 0; i < SPAN; i++)
        begin
            rank[i] = SEEN_W'($countones(s1_mask_reg & s1_before_reg[i]));
            sel[i]  = s1_mask_reg[i] && (rank[i] == (valid_cnt >> 1));
            median  = median | (s1_vals_reg[i] & {DATA_W{sel[i]}});
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= (valid_cnt == '0) ? s1_raw_reg : median;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_range = out_value_reg;
    assign last_of_scan   = out_last_reg;

    // A request in progress stays at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> job_valid)
        else $error("request left the queue while positions remain");

    // The center offset never passes the half span
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (dc_reg <= DC_W'(HALF_SPAN)))
        else $error("center offset out of range");

    // Ranks of valid samples pick exactly one median
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_mask_reg != '0)) |-> $onehot(sel))
        else $error("median select not one-hot");

    // Continuing a request happens only at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !step_last) |-> job.scan_end)
        else $error("multi-position request without scan end");

endmodule

// ===== hdl/gated_sliding_median_filter.sv =====
// Gated sliding median filter over a range scan. Accepts one range sample per
// cycle while the queue has room; scan_end marks a scan's last sample. Each
// position gets the upper median of the valid samples (inside [range_low_limit,
// range_high_limit], inclusive) of a centered 5-sample window cut at the scan
// edges, or the raw sample when none is valid. Results lag input by two
// positions; the scan_end sample flushes the pending positions, min(scan
// length, 3) results, the last one flagged by last_of_scan, and then starts a
// new scan. Throughput is one result per cycle with out_ready high, set by the
// single median unit in the back end; a scan_end sample occupies it for up to
// three positions while a 4-entry request queue keeps taking samples. The
// outputs are registered. Write the limits only while the block is idle.
module gated_sliding_median_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gsmf_pkg::DATA_W-1:0]        range_sample,
    input  logic                               scan_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gsmf_pkg::DATA_W-1:0]        filtered_range,
    output logic                               last_of_scan,
    input  logic                               cfg_we,
    input  logic [gsmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsmf_pkg::DATA_W-1:0]        cfg_data
);
    import gsmf_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;
    logic    fq_valid;
    logic    fq_ready;
    job_t    fq_job;
    logic    qb_valid;
    logic    qb_ready;
    job_t    qb_job;

    // Write configuration registers
    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  limits_next.low  = cfg_data;
                REG_RANGE_HIGH: limits_next.high = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg <= '{low: RANGE_LOW_RESET, high: RANGE_HIGH_RESET};
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    gsmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .range_sample (range_sample),
        .scan_end     (scan_end),
        .job_valid    (fq_valid),
        .job          (fq_job),
        .job_ready    (fq_ready)
    );

    gsmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    gsmf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .limits         (limits_reg),
        .job_valid      (qb_valid),
        .job_ready      (qb_ready),
        .job            (qb_job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_range (filtered_range),
        .last_of_scan   (last_of_scan)
    );

endmodule
